// File: rtl/dbss_pkg.sv
package dbss_pkg;

	localparam int DEPTH_W    = 16;
	localparam int IDX_W      = 20;
	localparam int LVL_W      = 8;
	localparam int DIM_CFG_W  = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// Restoring divider: one quotient bit per step.
	localparam int DIV_STEPS = LVL_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int NUM_W     = DEPTH_W + LVL_W;

	localparam logic [DEPTH_W-1:0]   NEAR_RST   = 16'd0;
	localparam logic [DEPTH_W-1:0]   FAR_RST    = 16'd65535;
	localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 11'd480;
	localparam logic [LVL_W-1:0]     LVL_MAX    = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR   = 3'd0,
		REG_FAR    = 3'd1,
		REG_MIRROR = 3'd2,
		REG_INVERT = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		LVL_FULL,
		LVL_ZERO,
		LVL_QUOT
	} lvl_mode_t;

	typedef struct packed {
		logic [DEPTH_W-1:0]   near_th;
		logic [DEPTH_W-1:0]   far_th;
		logic                 mirror;
		logic                 invert;
		logic [DIM_CFG_W-1:0] width;
		logic [DIM_CFG_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic div_step;
		logic load_out;
	} cmd_t;

endpackage

// File: rtl/depth_band_segment_and_scale_unit.sv
// Depth band segmentation and 8-bit scaling. Takes one 16-bit depth pixel per
// transaction in source raster order and returns one transaction per pixel:
// the destination index (columns flipped in mirror mode, rows flipped
// otherwise), the depth kept inside the near..far band (0 outside), an 8-bit
// texture level scaled over the band, and on the last pixel of a frame the
// band minimum and maximum. The next pixel is accepted only once the previous one
// has gone through prepare, the 8-step restoring divider that forms the
// texture level and the hand-over to the output register; a finished result waits in the output register
// while the next pixel is taken. Frame size is clamped to 1..MAX_WIDTH by
// 1..MAX_HEIGHT. Write configuration only while no transaction is in flight.
module depth_band_segment_and_scale_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dbss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dbss_pkg::DEPTH_W-1:0]        depth_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dbss_pkg::IDX_W-1:0]          dest_index,
	output logic [dbss_pkg::DEPTH_W-1:0]        kept_depth,
	output logic [dbss_pkg::LVL_W-1:0]          texture_level,
	output logic                                frame_done,
	output logic [dbss_pkg::DEPTH_W-1:0]        min_distance,
	output logic [dbss_pkg::DEPTH_W-1:0]        max_distance
);

	dbss_pkg::cfg_t cfg_q;
	dbss_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_th <= dbss_pkg::NEAR_RST;
			cfg_q.far_th  <= dbss_pkg::FAR_RST;
			cfg_q.mirror  <= 1'b0;
			cfg_q.invert  <= 1'b0;
			cfg_q.width   <= dbss_pkg::WIDTH_RST;
			cfg_q.height  <= dbss_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (dbss_pkg::reg_idx_t'(cfg_index))
				dbss_pkg::REG_NEAR:   cfg_q.near_th <= cfg_data;
				dbss_pkg::REG_FAR:    cfg_q.far_th  <= cfg_data;
				dbss_pkg::REG_MIRROR: cfg_q.mirror  <= cfg_data[0];
				dbss_pkg::REG_INVERT: cfg_q.invert  <= cfg_data[0];
				dbss_pkg::REG_WIDTH:  cfg_q.width   <= cfg_data[dbss_pkg::DIM_CFG_W-1:0];
				dbss_pkg::REG_HEIGHT: cfg_q.height  <= cfg_data[dbss_pkg::DIM_CFG_W-1:0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	dbss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dbss_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.depth_sample  (depth_sample),
		.dest_index    (dest_index),
		.kept_depth    (kept_depth),
		.texture_level (texture_level),
		.frame_done    (frame_done),
		.min_distance  (min_distance),
		.max_distance  (max_distance)
	);

endmodule

// File: rtl/dbss_ctrl.sv
module dbss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output dbss_pkg::cmd_t      cmd
);

	dbss_pkg::state_t                 state_q, state_d;
	logic [dbss_pkg::STEP_W-1:0]      step_q, step_d;
	logic                             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dbss_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dbss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = dbss_pkg::ST_PREP;
				end
			end
			dbss_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				step_d   = '0;
				state_d  = dbss_pkg::ST_DIV;
			end
			dbss_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == dbss_pkg::STEP_W'(dbss_pkg::DIV_STEPS - 1)) begin
					state_d = dbss_pkg::ST_FIN;
				end
			end
			dbss_pkg::ST_FIN: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = dbss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dbss_pkg::ST_IDLE;
			end
		endcase
		out_valid_d = cmd.load_out | (out_valid_q & ~out_ready);
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/dbss_datapath.sv
module dbss_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dbss_pkg::cfg_t                  cfg,
	input  dbss_pkg::cmd_t                  cmd,
	input  logic [dbss_pkg::DEPTH_W-1:0]    depth_sample,
	output logic [dbss_pkg::IDX_W-1:0]      dest_index,
	output logic [dbss_pkg::DEPTH_W-1:0]    kept_depth,
	output logic [dbss_pkg::LVL_W-1:0]      texture_level,
	output logic                            frame_done,
	output logic [dbss_pkg::DEPTH_W-1:0]    min_distance,
	output logic [dbss_pkg::DEPTH_W-1:0]    max_distance
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = WW + HW + 1;
	localparam int DW = dbss_pkg::DEPTH_W;
	localparam int NW = dbss_pkg::NUM_W;
	localparam int LW = dbss_pkg::LVL_W;

	// frame position and statistics
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [DW-1:0] min_q, max_q;

	// accepted sample and prepared per-pixel values
	logic [DW-1:0]             pix_q;
	logic [dbss_pkg::IDX_W-1:0] dest_q;
	logic [DW-1:0]             kept_q;
	logic                      done_q;
	logic [DW-1:0]             mn_q, mx_q;
	dbss_pkg::lvl_mode_t       mode_q;
	logic                      inv_q;

	// divider
	logic [NW-1:0] rem_q, dsh_q;
	logic [LW-1:0] quo_q;

	// output register
	logic [dbss_pkg::IDX_W-1:0] dest_out_q;
	logic [DW-1:0]              kept_out_q;
	logic [LW-1:0]              lvl_out_q;
	logic                       done_out_q;
	logic [DW-1:0]              mn_out_q, mx_out_q;

	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;
	logic          col_wrap, row_over, frame_start;
	logic [HW-1:0] row_a1;
	logic [CW-1:0] col_a1, col_a;
	logic [RW-1:0] row_a;
	logic [DW-1:0] min_base, max_base, min_n, max_n;
	logic          ge_near, le_far;
	logic [DW-1:0] p1, kept_c;
	logic [HW-1:0] mul_a;
	logic [WW-1:0] add_b;
	logic [PW-1:0] dest_sum;
	logic          done_c;
	logic [DW-1:0] mn_c, mx_c;
	logic [WW-1:0] col_i;
	logic [HW-1:0] row_i;
	logic [DW-1:0] diff, den;
	logic [NW-1:0] num;
	dbss_pkg::lvl_mode_t mode_c;
	logic [LW-1:0] lvl_c;

	always_comb begin
		if (cfg.width == '0) begin
			w_c = WW'(1);
		end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(cfg.width);
		end
		if (cfg.height == '0) begin
			h_c = HW'(1);
		end else if (32'(cfg.height) > 32'(MAX_HEIGHT)) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(cfg.height);
		end

		// position fix-up for geometry that shrank under the counters
		col_wrap = WW'(col_q) >= w_c;
		row_a1   = col_wrap ? HW'(row_q) + HW'(1) : HW'(row_q);
		col_a1   = col_wrap ? '0 : col_q;
		row_over = row_a1 >= h_c;
		row_a    = row_over ? '0 : row_a1[RW-1:0];
		col_a    = row_over ? '0 : col_a1;
		frame_start = (row_a == '0) && (col_a == '0);

		min_base = frame_start ? cfg.far_th : min_q;
		max_base = frame_start ? cfg.near_th : max_q;

		// the minimum sees the raw sample, the maximum sees it after the near cut
		ge_near = pix_q >= cfg.near_th;
		min_n   = (ge_near && (min_base > pix_q)) ? pix_q : min_base;
		p1      = ge_near ? pix_q : '0;
		le_far  = p1 <= cfg.far_th;
		max_n   = (le_far && (max_base < p1)) ? p1 : max_base;
		kept_c  = le_far ? p1 : '0;

		if (cfg.mirror) begin
			mul_a = HW'(row_a);
			add_b = w_c - WW'(1) - WW'(col_a);
		end else begin
			mul_a = h_c - HW'(1) - HW'(row_a);
			add_b = WW'(col_a);
		end
		dest_sum = PW'(mul_a) * PW'(w_c) + PW'(add_b);

		done_c = (WW'(col_a) == w_c - WW'(1)) && (HW'(row_a) == h_c - HW'(1));
		mn_c   = '0;
		mx_c   = '0;
		if (done_c) begin
			mn_c = (min_n == cfg.far_th) ? cfg.near_th : min_n;
			mx_c = (max_n == cfg.near_th) ? cfg.far_th : max_n;
		end

		col_i = WW'(col_a) + WW'(1);
		row_i = HW'(row_a) + HW'(1);

		// 255 * (v - near) as (diff << 8) - diff
		diff = kept_c - cfg.near_th;
		den  = cfg.far_th - cfg.near_th;
		num  = {diff, {LW{1'b0}}} - NW'(diff);

		priority if (kept_c < cfg.near_th) begin
			mode_c = dbss_pkg::LVL_FULL;
		end else if (cfg.far_th <= cfg.near_th) begin
			mode_c = dbss_pkg::LVL_ZERO;
		end else begin
			mode_c = dbss_pkg::LVL_QUOT;
		end

		unique case (mode_q)
			dbss_pkg::LVL_FULL: lvl_c = dbss_pkg::LVL_MAX;
			dbss_pkg::LVL_ZERO: lvl_c = '0;
			dbss_pkg::LVL_QUOT: lvl_c = inv_q ? ~quo_q : quo_q;
			default:            lvl_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			min_q <= dbss_pkg::FAR_RST;
			max_q <= dbss_pkg::NEAR_RST;
		end else if (cmd.prep) begin
			min_q <= min_n;
			max_q <= max_n;
			// advance the raster position, wrap at row and frame end
			if (col_i >= w_c) begin
				col_q <= '0;
				row_q <= (row_i >= h_c) ? '0 : row_i[RW-1:0];
			end else begin
				col_q <= col_i[CW-1:0];
				row_q <= row_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= depth_sample;
		end
		if (cmd.prep) begin
			dest_q <= dbss_pkg::IDX_W'(dest_sum);
			kept_q <= kept_c;
			done_q <= done_c;
			mn_q   <= mn_c;
			mx_q   <= mx_c;
			mode_q <= mode_c;
			inv_q  <= cfg.invert;
			rem_q  <= num;
			dsh_q  <= NW'({den, {(LW-1){1'b0}}});
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[LW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[LW-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.load_out) begin
			dest_out_q <= dest_q;
			kept_out_q <= kept_q;
			lvl_out_q  <= lvl_c;
			done_out_q <= done_q;
			mn_out_q   <= mn_q;
			mx_out_q   <= mx_q;
		end
	end

	assign dest_index    = dest_out_q;
	assign kept_depth    = kept_out_q;
	assign texture_level = lvl_out_q;
	assign frame_done    = done_out_q;
	assign min_distance  = mn_out_q;
	assign max_distance  = mx_out_q;

endmodule

// File: sim/tb.sv
module tb;
	import dbss_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RANDOM_PIXELS  = 1150;
	localparam int PHASES         = 8;
	localparam int MAX_DIM        = 1024;

	typedef struct packed {
		logic [IDX_W-1:0]   dest;
		logic [DEPTH_W-1:0] kept;
		logic [LVL_W-1:0]   level;
		logic               done;
		logic [DEPTH_W-1:0] min_d;
		logic [DEPTH_W-1:0] max_d;
	} px_result_t;

	typedef struct packed {
		logic       on;
		px_result_t px;
	} pinned_px_t;

	typedef enum logic {
		ROW_WRITE,
		ROW_PIXEL
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  pinned;
		px_result_t            px;
	} plan_row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [DEPTH_W-1:0]    depth_sample = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [IDX_W-1:0]      dest_index;
	logic [DEPTH_W-1:0]    kept_depth;
	logic [LVL_W-1:0]      texture_level;
	logic                  frame_done;
	logic [DEPTH_W-1:0]    min_distance;
	logic [DEPTH_W-1:0]    max_distance;

	// shadow of the register file and the frame position
	logic [DEPTH_W-1:0]   near_th    = NEAR_RST;
	logic [DEPTH_W-1:0]   far_th     = FAR_RST;
	logic                 mirror_on  = 1'b0;
	logic                 invert_on  = 1'b0;
	logic [DIM_CFG_W-1:0] width_cfg  = WIDTH_RST;
	logic [DIM_CFG_W-1:0] height_cfg = HEIGHT_RST;
	int unsigned          col_pos    = 0;
	int unsigned          row_pos    = 0;
	logic [DEPTH_W-1:0]   band_min   = FAR_RST;
	logic [DEPTH_W-1:0]   band_max   = NEAR_RST;

	px_result_t due_px[$];
	pinned_px_t pinned_q[$];
	plan_row_t  bench_plan[$];
	int         error_count    = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	int         quiet_cycles   = 0;

	depth_band_segment_and_scale_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.depth_sample(depth_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_index(dest_index),
		.kept_depth(kept_depth),
		.texture_level(texture_level),
		.frame_done(frame_done),
		.min_distance(min_distance),
		.max_distance(max_distance)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic px_result_t segment_pixel(input logic [DEPTH_W-1:0] sample);
		int unsigned w, h, p, nr, fr, lvl, dest;
		px_result_t r;
		w = (width_cfg == 0) ? 1 : (width_cfg > MAX_DIM) ? MAX_DIM : width_cfg;
		h = (height_cfg == 0) ? 1 : (height_cfg > MAX_DIM) ? MAX_DIM : height_cfg;
		nr = near_th;
		fr = far_th;
		p = sample;
		// wrap a position left stale by a smaller geometry
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (row_pos == 0 && col_pos == 0) begin
			band_min = far_th;
			band_max = near_th;
		end
		if (p < nr) p = 0;
		else if (band_min > p) band_min = DEPTH_W'(p);
		if (p > fr) p = 0;
		else if (band_max < p) band_max = DEPTH_W'(p);
		if (mirror_on) dest = row_pos * w + (w - 1 - col_pos);
		else dest = (h - 1 - row_pos) * w + col_pos;
		if (p > fr) lvl = 0;
		else if (p < nr) lvl = LVL_MAX;
		else if (fr <= nr) lvl = 0;
		else begin
			lvl = (LVL_MAX * (p - nr)) / (fr - nr);
			if (invert_on) lvl = LVL_MAX - lvl;
		end
		r.dest  = IDX_W'(dest);
		r.kept  = DEPTH_W'(p);
		r.level = LVL_W'(lvl);
		r.done  = (col_pos == w - 1) && (row_pos == h - 1);
		r.min_d = '0;
		r.max_d = '0;
		if (r.done) begin
			r.min_d = (band_min == far_th) ? near_th : band_min;
			r.max_d = (band_max == near_th) ? far_th : band_max;
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		pinned_px_t pin;
		px_result_t want;
		if (in_valid && in_ready) begin
			want = segment_pixel(depth_sample);
			if (pinned_q.size() != 0) begin
				pin = pinned_q.pop_front();
				if (pin.on) want = pin.px;
			end
			due_px.push_back(want);
		end
		if (out_valid && out_ready) begin
			if (due_px.size() == 0) begin
				error_count++;
				$error("transaction with nothing pending, dest_index %0d", dest_index);
			end else begin
				want = due_px.pop_front();
				check_field("dest_index", want.dest, dest_index);
				check_field("kept_depth", want.kept, kept_depth);
				check_field("texture_level", want.level, texture_level);
				check_field("frame_done", want.done, frame_done);
				check_field("min_distance", want.min_d, min_distance);
				check_field("max_distance", want.max_d, max_distance);
			end
		end
	end

	always @(posedge clk) out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_pixel(input logic [DEPTH_W-1:0] sample, input logic pinned,
			input px_result_t px);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pinned_q.push_back('{pinned, px});
		in_valid <= 1'b1;
		depth_sample <= sample;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// hold the input until every pending result is out
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_px.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
		REG_NEAR: near_th = data;
		REG_FAR: far_th = data;
		REG_MIRROR: mirror_on = data[0];
		REG_INVERT: invert_on = data[0];
		REG_WIDTH: width_cfg = data[DIM_CFG_W-1:0];
		REG_HEIGHT: height_cfg = data[DIM_CFG_W-1:0];
		default: ;
		endcase
	endtask

	// mostly tiny frames so that frames complete; upper data bits are noise
	function automatic logic [CFG_DATA_W-1:0] random_dim();
		logic [CFG_DATA_W-1:0] v;
		int unsigned pick;
		v = CFG_DATA_W'($urandom);
		pick = $urandom_range(19, 0);
		if (pick == 0) v[DIM_CFG_W-1:0] = '0;
		else if (pick == 1) v[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(24, 9));
		else v[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(8, 1));
		return v;
	endfunction

	function automatic logic [DEPTH_W-1:0] pick_depth();
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 55 && near_th <= far_th) return DEPTH_W'($urandom_range(far_th, near_th));
		if (pick < 60) return near_th;
		if (pick < 65) return far_th;
		if (pick < 68) return near_th - 1'b1;
		if (pick < 71) return far_th + 1'b1;
		if (pick < 77) return '0;
		if (pick < 83) return '1;
		return DEPTH_W'($urandom);
	endfunction

	task automatic pick_config(input logic every);
		logic [DEPTH_W-1:0] lo, hi;
		if (every || $urandom_range(1, 0)) begin
			case ($urandom_range(5, 0))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: begin
				lo = DEPTH_W'($urandom);
				hi = DEPTH_W'($urandom);
			end
			2: begin
				lo = DEPTH_W'($urandom_range(60000, 0));
				hi = lo + DEPTH_W'($urandom_range(5000, 1));
			end
			3: begin
				lo = DEPTH_W'($urandom_range(1000, 0));
				hi = lo + DEPTH_W'($urandom_range(300, 0));
			end
			4: begin
				lo = '0;
				hi = DEPTH_W'($urandom);
			end
			default: begin
				lo = DEPTH_W'($urandom);
				hi = '1;
			end
			endcase
			write_reg(REG_NEAR, lo);
			write_reg(REG_FAR, hi);
		end
		if (every || $urandom_range(2, 0) == 0) write_reg(REG_MIRROR, CFG_DATA_W'($urandom));
		if (every || $urandom_range(2, 0) == 0) write_reg(REG_INVERT, CFG_DATA_W'($urandom));
		if (every || $urandom_range(1, 0)) write_reg(REG_WIDTH, random_dim());
		if (every || $urandom_range(1, 0)) write_reg(REG_HEIGHT, random_dim());
	endtask

	function automatic plan_row_t reg_row(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		return '{ROW_WRITE, idx, data, 1'b0, '0};
	endfunction

	function automatic plan_row_t pix_row(input logic [DEPTH_W-1:0] sample);
		return '{ROW_PIXEL, REG_NEAR, sample, 1'b0, '0};
	endfunction

	function automatic plan_row_t pix_chk(input logic [DEPTH_W-1:0] sample,
			input logic [IDX_W-1:0] dest, input logic [DEPTH_W-1:0] kept,
			input logic [LVL_W-1:0] level, input logic done,
			input logic [DEPTH_W-1:0] min_d, input logic [DEPTH_W-1:0] max_d);
		return '{ROW_PIXEL, REG_NEAR, sample, 1'b1, '{dest, kept, level, done, min_d, max_d}};
	endfunction

	initial begin
		int per_phase, hold_at;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bench_plan = {
			// reset geometry 640x480, rows flipped
			pix_chk(16'h0000, 20'd306560, 16'h0000, 8'd0, 1'b0, 16'd0, 16'd0),
			pix_chk(16'hFFFF, 20'd306561, 16'hFFFF, 8'd255, 1'b0, 16'd0, 16'd0),
			// shrink mid-frame: wraps onto the next row
			reg_row(REG_WIDTH, 16'd2),
			reg_row(REG_HEIGHT, 16'd2),
			pix_row(16'h1234),
			pix_row(16'h00FF),
			// one-pixel frames: every transaction reports the band
			reg_row(REG_NEAR, 16'd1000),
			reg_row(REG_FAR, 16'd2000),
			reg_row(REG_MIRROR, 16'd1),
			reg_row(REG_WIDTH, 16'd0),
			reg_row(REG_HEIGHT, 16'd0),
			pix_chk(16'd999, 20'd0, 16'd0, 8'd255, 1'b1, 16'd1000, 16'd2000),
			pix_chk(16'd2001, 20'd0, 16'd0, 8'd255, 1'b1, 16'd1000, 16'd2000),
			pix_chk(16'd1000, 20'd0, 16'd1000, 8'd0, 1'b1, 16'd1000, 16'd2000),
			pix_chk(16'd2000, 20'd0, 16'd2000, 8'd255, 1'b1, 16'd1000, 16'd2000),
			pix_chk(16'd1500, 20'd0, 16'd1500, 8'd127, 1'b1, 16'd1500, 16'd1500),
			reg_row(REG_INVERT, 16'd1),
			pix_chk(16'd1500, 20'd0, 16'd1500, 8'd128, 1'b1, 16'd1500, 16'd1500),
			pix_chk(16'd1000, 20'd0, 16'd1000, 8'd255, 1'b1, 16'd1000, 16'd2000),
			// empty band
			reg_row(REG_FAR, 16'd1000),
			pix_chk(16'd1000, 20'd0, 16'd1000, 8'd0, 1'b1, 16'd1000, 16'd1000),
			pix_chk(16'd5, 20'd0, 16'd0, 8'd255, 1'b1, 16'd1000, 16'd1000),
			reg_row(REG_NEAR, 16'd0),
			reg_row(REG_FAR, 16'd0),
			pix_chk(16'h0000, 20'd0, 16'd0, 8'd0, 1'b1, 16'd0, 16'd0),
			pix_chk(16'hFFFF, 20'd0, 16'd0, 8'd0, 1'b1, 16'd0, 16'd0),
			// largest frame, width written out of range
			reg_row(REG_FAR, 16'hFFFF),
			reg_row(REG_MIRROR, 16'd0),
			reg_row(REG_INVERT, 16'd0),
			reg_row(REG_WIDTH, 16'hFFFF),
			reg_row(REG_HEIGHT, 16'h0400),
			pix_chk(16'h8000, 20'd1047552, 16'h8000, 8'd127, 1'b0, 16'd0, 16'd0),
			pix_row(16'h7FFF),
			reg_row(REG_MIRROR, 16'd1),
			pix_row(16'hAAAA),
			pix_row(16'h5555),
			reg_row(REG_WIDTH, 16'd3),
			reg_row(REG_HEIGHT, 16'd2),
			pix_row(16'h0001),
			pix_row(16'h0002),
			pix_row(16'h0003)
		};

		foreach (bench_plan[i]) begin
			if (bench_plan[i].kind == ROW_WRITE) begin
				drain(SETTLE_CYCLES);
				write_reg(bench_plan[i].idx, bench_plan[i].data);
			end else begin
				push_pixel(bench_plan[i].data, bench_plan[i].pinned, bench_plan[i].px);
			end
		end

		per_phase = RANDOM_PIXELS / PHASES;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain(SETTLE_CYCLES);
			pick_config(ph == 0);
			case (ph % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 59;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 59;
			end
			default: begin
				send_idle_pct = 21;
				recv_stall_pct = 21;
			end
			endcase
			hold_at = $urandom_range(per_phase - 1, 0);
			for (int k = 0; k < per_phase; k++) begin
				if (k == hold_at) drain(0);
				push_pixel(pick_depth(), 1'b0, '0);
			end
		end

		drain(20);
		if (error_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
rtl/dbss_pkg.sv
rtl/dbss_ctrl.sv
rtl/dbss_datapath.sv
rtl/depth_band_segment_and_scale_unit.sv
sim/tb.sv
